### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rmc_pkg.sv
package rmc_pkg;

  localparam int SENTENCE_BYTES = 64;
  localparam int TIME_CHARS     = 9;
  localparam int COORD_CHARS    = 14;

  localparam int HDR_LEN    = 7;
  localparam int NUM_FIELDS = 6;
  localparam int MAX_POS    = 9;

  localparam int ADDR_W = $clog2(SENTENCE_BYTES);
  localparam int MAX_CHARS = (TIME_CHARS > COORD_CHARS) ? TIME_CHARS : COORD_CHARS;
  localparam int IDX_W  = $clog2(MAX_CHARS + 1);
  localparam int CMP_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam int CC_W   = $clog2(MAX_POS + 2);
  localparam int FILL_W = $clog2(HDR_LEN + 1);
  localparam int CODE_W = 3;
  localparam int FSEL_W = $clog2(NUM_FIELDS);

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [7:0] RMC_HEADER [HDR_LEN] =
    '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43, 8'h2C};

  // Field codes, also the emission order.
  localparam logic [CODE_W-1:0] FC_TIME = 3'd0;
  localparam logic [CODE_W-1:0] FC_DATE = 3'd1;
  localparam logic [CODE_W-1:0] FC_LAT  = 3'd2;
  localparam logic [CODE_W-1:0] FC_NS   = 3'd3;
  localparam logic [CODE_W-1:0] FC_LON  = 3'd4;
  localparam logic [CODE_W-1:0] FC_EW   = 3'd5;
  localparam logic [CODE_W-1:0] FC_END  = 3'd6;

  // Comma position of each field slot, indexed by field code.
  localparam logic [CC_W-1:0] FIELD_POS [NUM_FIELDS] =
    '{CC_W'(1), CC_W'(9), CC_W'(3), CC_W'(4), CC_W'(5), CC_W'(6)};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIELD,
    ST_FETCH,
    ST_SEND
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic run_start;
    logic field_next;
    logic rd_en;
    logic space_sel;
    logic idx_inc;
    logic run_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic is_star;
    logic is_end;
    logic need_fetch;
    logic need_space;
  } dp_status_t;

  function automatic logic [IDX_W-1:0] field_limit(input logic [CODE_W-1:0] code);
    logic [IDX_W-1:0] lim;
    case (code) inside
      FC_TIME, FC_DATE: lim = IDX_W'(TIME_CHARS);
      FC_LAT, FC_LON:   lim = IDX_W'(COORD_CHARS);
      default:          lim = IDX_W'(1);
    endcase
    return lim;
  endfunction

endpackage

### rtl/core/rmc_byte_if.sv
interface rmc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/core/rmc_result_if.sv
interface rmc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] field_code;
  logic [7:0] char_value;
  logic       last;

  modport source (output valid, output field_code, output char_value, output last,
                  input ready);
  modport sink (input valid, input field_code, input char_value, input last,
                output ready);
endinterface

### rtl/core/nmea_rmc_field_extractor_core.sv
// Channel   | Dir | Payload                          | Meaning
// byte_ch   | in  | rx_byte[7:0]                     | received NMEA character
// field_ch  | out | field_code[2:0] char_value[7:0]  | extracted field character,
//           |     | last                             | last marks the end marker
//
// An ordinary byte is taken and, while a sentence is being captured, written
// to the sentence store. A '*' byte starts a run and holds byte_ch.ready low
// until the end marker is taken. Each stored character passes a decision
// state, a registered store read and an output state; each hemisphere space
// or end marker a decision state and an output state; each advance to the
// next field a decision state alone. Output stalls simply hold the current item.
// Reset (rst, synchronous) clears the window fill, capture flag, store length
// and walk state; the store contents are left as they are.

module nmea_rmc_field_extractor_core
  import rmc_pkg::*;
(
  input logic          clk,
  input logic          rst,
  rmc_byte_if.sink     byte_ch,
  rmc_result_if.source field_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: takes bytes, then walks the six fields and the end marker.
  rmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_ch.valid),
    .in_ready  (byte_ch.ready),
    .out_valid (field_ch.valid),
    .out_ready (field_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Header window, sentence store with per-field start/length tracking,
  // and the output character path.
  rmc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rx_byte    (byte_ch.rx_byte),
    .status     (status),
    .field_code (field_ch.field_code),
    .char_value (field_ch.char_value),
    .last       (field_ch.last)
  );

endmodule

### rtl/core/rmc_datapath.sv
`include "assert_macros.svh"

module rmc_datapath
  import rmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  logic [7:0]        rx_byte,
  output dp_status_t        status,
  output logic [CODE_W-1:0] field_code,
  output logic [7:0]        char_value,
  output logic              last
);

  localparam logic [ADDR_W-1:0] STORE_MAX = ADDR_W'(SENTENCE_BYTES - 1);
  localparam logic [CC_W-1:0]   CC_SAT    = CC_W'(MAX_POS + 1);

  logic [7:0]        window [HDR_LEN];
  logic [7:0]        window_sh [HDR_LEN];
  logic [FILL_W-1:0] window_fill;
  logic              capturing;
  logic              capturing_next;
  logic              hdr_match;

  logic [7:0]        mem [SENTENCE_BYTES];
  logic [ADDR_W-1:0] store_length;
  logic [CC_W-1:0]   comma_count;
  logic [CC_W-1:0]   cc_inc;
  logic [ADDR_W-1:0] fld_start [NUM_FIELDS];
  logic [ADDR_W-1:0] fld_len [NUM_FIELDS];
  logic              store_en;
  logic              is_star;

  logic [CODE_W-1:0] code;
  logic [IDX_W-1:0]  char_idx;
  logic              use_space;
  logic [7:0]        rdata;
  logic [FSEL_W-1:0] fsel;
  logic              is_end;
  logic [ADDR_W-1:0] cur_len;
  logic [ADDR_W-1:0] cur_start;
  logic [CMP_W-1:0]  lim;
  logic [CMP_W-1:0]  maxc;
  logic [ADDR_W-1:0] rd_addr;

  // Header window: shift in every accepted byte.
  always_comb begin
    for (int i = 0; i < HDR_LEN - 1; i++) begin
      window_sh[i] = window[i+1];
    end
    window_sh[HDR_LEN-1] = rx_byte;
    hdr_match = (window_fill >= FILL_W'(HDR_LEN - 1));
    for (int i = 0; i < HDR_LEN; i++) begin
      if (window_sh[i] != RMC_HEADER[i]) begin
        hdr_match = 1'b0;
      end
    end
  end

  assign is_star = (rx_byte == STAR_CHAR);

  always_comb begin
    capturing_next = capturing;
    if (hdr_match) begin
      capturing_next = 1'b1;
    end
    if (is_star) begin
      capturing_next = 1'b0;
    end
  end

  assign store_en = cmd.accept && capturing_next && (store_length < STORE_MAX);
  assign cc_inc   = (comma_count == CC_SAT) ? comma_count : comma_count + CC_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      window <= window_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill <= '0;
      capturing   <= 1'b0;
    end else if (cmd.accept) begin
      capturing <= capturing_next;
      if (window_fill != FILL_W'(HDR_LEN)) begin
        window_fill <= window_fill + FILL_W'(1);
      end
    end
  end

  // Store and per-field bookkeeping, updated as bytes arrive.
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[store_length] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.run_clear) begin
      store_length <= '0;
      comma_count  <= '0;
      for (int s = 0; s < NUM_FIELDS; s++) begin
        fld_len[s] <= '0;
      end
    end else if (store_en) begin
      store_length <= store_length + ADDR_W'(1);
      if (rx_byte == COMMA_CHAR) begin
        comma_count <= cc_inc;
        for (int s = 0; s < NUM_FIELDS; s++) begin
          if (cc_inc == FIELD_POS[s] && comma_count != CC_SAT) begin
            fld_len[s] <= '0;
          end
        end
      end else begin
        for (int s = 0; s < NUM_FIELDS; s++) begin
          if (comma_count == FIELD_POS[s]) begin
            fld_len[s] <= fld_len[s] + ADDR_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_en && rx_byte == COMMA_CHAR && comma_count != CC_SAT) begin
      for (int s = 0; s < NUM_FIELDS; s++) begin
        if (cc_inc == FIELD_POS[s]) begin
          fld_start[s] <= store_length + ADDR_W'(1);
        end
      end
    end
  end

  // Emission walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      code      <= FC_TIME;
      char_idx  <= '0;
      use_space <= 1'b0;
    end else begin
      if (cmd.run_start) begin
        code     <= FC_TIME;
        char_idx <= '0;
      end else if (cmd.field_next) begin
        code     <= code + CODE_W'(1);
        char_idx <= '0;
      end else if (cmd.idx_inc) begin
        char_idx <= char_idx + IDX_W'(1);
      end
      if (cmd.rd_en) begin
        use_space <= 1'b0;
      end else if (cmd.space_sel) begin
        use_space <= 1'b1;
      end
    end
  end

  assign is_end    = (code == FC_END);
  assign fsel      = FSEL_W'(code);
  assign cur_len   = is_end ? '0 : fld_len[fsel];
  assign cur_start = is_end ? '0 : fld_start[fsel];
  assign maxc      = CMP_W'(field_limit(code));
  assign lim       = (CMP_W'(cur_len) < maxc) ? CMP_W'(cur_len) : maxc;
  assign rd_addr   = cur_start + ADDR_W'(char_idx);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    status.is_star    = is_star;
    status.is_end     = is_end;
    status.need_fetch = !is_end && (CMP_W'(char_idx) < lim);
    status.need_space = (code == FC_NS || code == FC_EW) && (cur_len == '0)
                        && (char_idx == '0);
  end

  assign field_code = code;
  assign last       = is_end;
  assign char_value = is_end ? 8'h00 : (use_space ? SPACE_CHAR : rdata);

  `RMC_ASSERT_IMP(a_read_written, clk, rst, cmd.rd_en, rd_addr < store_length, "read beyond stored bytes")
  `RMC_ASSERT_IMP(a_star_not_stored, clk, rst, cmd.accept && is_star, !store_en, "star byte stored")
  `RMC_ASSERT_IMP(a_no_store_in_run, clk, rst, cmd.rd_en || cmd.field_next, !store_en, "store written during run")

endmodule

### rtl/core/rmc_ctrl.sv
`include "assert_macros.svh"

module rmc_ctrl
  import rmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.is_star) begin
          state_next = ST_FIELD;
        end
      end
      ST_FIELD: begin
        if (status.is_end) begin
          state_next = ST_SEND;
        end else if (status.need_fetch) begin
          state_next = ST_FETCH;
        end else if (status.need_space) begin
          state_next = ST_SEND;
        end
      end
      ST_FETCH: state_next = ST_SEND;
      ST_SEND: begin
        if (out_ready) begin
          state_next = status.is_end ? ST_IDLE : ST_FIELD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.accept    = in_valid;
        cmd.run_start = in_valid && status.is_star;
      end
      ST_FIELD: begin
        if (!status.is_end && !status.need_fetch) begin
          if (status.need_space) begin
            cmd.space_sel = 1'b1;
          end else begin
            cmd.field_next = 1'b1;
          end
        end
      end
      ST_FETCH: cmd.rd_en = 1'b1;
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.run_clear = status.is_end;
          cmd.idx_inc   = !status.is_end;
        end
      end
      default: ;
    endcase
  end

  `RMC_ASSERT_IMP(a_chan_excl, clk, rst, out_valid, !in_ready, "result offered while taking input")
  `RMC_ASSERT_NEXT(a_end_to_idle, clk, rst, out_valid && out_ready && status.is_end, in_ready, "run end did not return to idle")
  `RMC_ASSERT_NEXT(a_star_blocks, clk, rst, in_valid && in_ready && status.is_star, !in_ready, "input taken after star")

endmodule

### tb/nmea_rmc_field_extractor_core_tb.sv
module nmea_rmc_field_extractor_core_tb;
  import rmc_pkg::*;

  // Comma positions of the RMC fields that the block pulls out.
  localparam int unsigned POS_TIME = 1;
  localparam int unsigned POS_LAT  = 3;
  localparam int unsigned POS_NS   = 4;
  localparam int unsigned POS_LON  = 5;
  localparam int unsigned POS_EW   = 6;
  localparam int unsigned POS_DATE = 9;

  // Marker in the byte queue: hold the sender until every field char is back.
  localparam int DRAIN_MARK = -1;

  localparam int RANDOM_BYTES     = 380;
  localparam int CALM_TAIL        = 80;
  localparam int LONG_HOLD_AFTER  = 150;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT      = 4000;
  localparam int TAIL_CYCLES      = 60;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [7:0]        ch;
    logic              last;
  } field_char_t;

  logic clk;
  logic rst = 1'b1;

  rmc_byte_if   byte_ch ();
  rmc_result_if field_ch ();

  nmea_rmc_field_extractor_core dut (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .field_ch (field_ch)
  );

  // Bytes still to send, and field chars the sentence parser says must come out.
  int          pending_bytes [$];
  field_char_t field_chars_due [$];

  // Parser shadow state: header window, capture flag and sentence buffer.
  logic [7:0]  hdr_win [HDR_LEN];
  int unsigned hdr_fill;
  bit          in_sentence;
  logic [7:0]  sent_buf [SENTENCE_BYTES];
  int unsigned sent_len;

  int bytes_taken;
  int send_gap;
  int hold_left;
  bit long_hold_done;
  int fail_count;
  int idle_cycles;

  field_char_t got;
  field_char_t want;

  // Find field number pos in the sentence buffer. Empty fields keep their
  // place; the last field may run to the end of the buffer with no comma.
  function automatic void find_field(input int unsigned pos, output int unsigned start,
                                     output int unsigned len);
    int unsigned commas;
    bit hit;
    commas = 0;
    hit    = 0;
    start  = 0;
    len    = 0;
    for (int unsigned i = 0; i < sent_len; i++) begin
      if (sent_buf[i] == COMMA_CHAR) begin
        if (commas == pos) begin
          hit = 1;
          break;
        end
        commas++;
        start = i + 1;
        len   = 0;
      end else begin
        len++;
      end
    end
    if (!hit && commas != pos) begin
      start = 0;
      len   = 0;
    end
  endfunction

  function automatic void queue_field_text(input logic [CODE_W-1:0] code,
                                           input int unsigned pos, input int unsigned maxc);
    int unsigned s;
    int unsigned n;
    find_field(pos, s, n);
    if (n > maxc) n = maxc;
    for (int unsigned i = 0; i < n; i++)
      field_chars_due.push_back('{code: code, ch: sent_buf[s + i], last: 1'b0});
  endfunction

  // Hemisphere fields always give exactly one char: the first, or a space.
  function automatic void queue_field_letter(input logic [CODE_W-1:0] code,
                                             input int unsigned pos);
    int unsigned s;
    int unsigned n;
    find_field(pos, s, n);
    field_chars_due.push_back('{code: code, ch: (n != 0) ? sent_buf[s] : SPACE_CHAR,
                                last: 1'b0});
  endfunction

  // Advance the parser shadow by one received byte and queue what it yields.
  function automatic void rmc_parse_byte(input logic [7:0] b);
    bit match;
    if (hdr_fill < HDR_LEN) begin
      hdr_win[hdr_fill] = b;
      hdr_fill++;
    end else begin
      for (int i = 0; i < HDR_LEN - 1; i++) hdr_win[i] = hdr_win[i + 1];
      hdr_win[HDR_LEN - 1] = b;
    end
    match = 1;
    for (int i = 0; i < HDR_LEN; i++)
      if (hdr_win[i] != RMC_HEADER[i]) match = 0;
    if (match) in_sentence = 1;

    if (b == STAR_CHAR) begin
      in_sentence = 0;
      queue_field_text(FC_TIME, POS_TIME, TIME_CHARS);
      queue_field_text(FC_DATE, POS_DATE, TIME_CHARS);
      queue_field_text(FC_LAT, POS_LAT, COORD_CHARS);
      queue_field_letter(FC_NS, POS_NS);
      queue_field_text(FC_LON, POS_LON, COORD_CHARS);
      queue_field_letter(FC_EW, POS_EW);
      field_chars_due.push_back('{code: FC_END, ch: 8'h00, last: 1'b1});
      sent_len = 0;
    end

    // Saturate: one entry of the buffer is never filled.
    if (in_sentence && sent_len < SENTENCE_BYTES - 1) begin
      sent_buf[sent_len] = b;
      sent_len++;
    end
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(int'(s[i]));
  endfunction

  // Field content: mostly digits and dots, some letters, some arbitrary bytes,
  // but never a comma or a star.
  function automatic int field_byte();
    int r;
    int c;
    string pick;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      pick = "0123456789.";
      c = int'(pick[$urandom_range(0, pick.len() - 1)]);
    end else if (r == 7) begin
      pick = "NSEWAV";
      c = int'(pick[$urandom_range(0, pick.len() - 1)]);
    end else begin
      do c = $urandom_range(0, 255);
      while (c == COMMA_CHAR || c == STAR_CHAR);
    end
    return c;
  endfunction

  // Shapes: 0 line noise, 1 broken header, 2 overlong sentence that saturates
  // the buffer, 3 header repeated inside a sentence, anything else a normal one.
  function automatic void queue_random_sentence(input int shape);
    int nfields;
    int flen;
    int c;
    if (shape == 0) begin
      repeat ($urandom_range(1, 8)) pending_bytes.push_back($urandom_range(0, 255));
      return;
    end
    if (shape == 1) begin
      push_text("$GPRM");
      do c = $urandom_range(0, 255);
      while (c == "C");
      pending_bytes.push_back(c);
      push_text(",");
    end else begin
      push_text("$GPRMC,");
    end
    nfields = (shape == 2) ? 14 : $urandom_range(0, 13);
    for (int f = 0; f < nfields; f++) begin
      if (shape == 2)
        flen = $urandom_range(5, 10);
      else if ($urandom_range(0, 9) == 0)
        flen = $urandom_range(10, 18);
      else
        flen = $urandom_range(0, 4);
      repeat (flen) pending_bytes.push_back(field_byte());
      if (shape == 3 && f == 2) push_text("$GPRMC,");
      if (f != nfields - 1) push_text(",");
    end
    push_text("*");
    if ($urandom_range(0, 1) == 1) push_text("4F\r\n");
  endfunction

  // 10-unit clock; all block inputs known from time zero.
  initial begin
    clk = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;
    field_ch.ready  = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: offer queued bytes, idle in bursts, hold at drain markers.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        rmc_parse_byte(byte_ch.rx_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        // Release a drain marker only once the last run has fully come out.
        if (pending_bytes.size() > 0 && pending_bytes[0] == DRAIN_MARK &&
            field_chars_due.size() == 0)
          void'(pending_bytes.pop_front());
        if (send_gap > 0) begin
          send_gap--;
          byte_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0 && pending_bytes[0] != DRAIN_MARK) begin
          if (pending_bytes.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 10) - 1;
            byte_ch.valid <= 1'b0;
          end else begin
            byte_ch.valid   <= 1'b1;
            byte_ch.rx_byte <= 8'(pending_bytes.pop_front());
          end
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each field char against the oldest one due, and stall
  // the output side at random, plus one long hold while a run is in flight.
  always @(posedge clk) begin
    if (rst) begin
      field_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (field_ch.valid && field_ch.ready) begin
        got = '{code: field_ch.field_code, ch: field_ch.char_value, last: field_ch.last};
        if (field_chars_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("field char with none due: code %0d char %h last %0d",
                     got.code, got.ch, got.last);
        end else begin
          want = field_chars_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("field char wrong: code %0d/%0d char %h/%h last %0d/%0d (want/got)",
                       want.code, got.code, want.ch, got.ch, want.last, got.last);
          end
        end
      end

      if (hold_left > 0) begin
        hold_left--;
        field_ch.ready <= 1'b0;
      end else if (!long_hold_done && bytes_taken >= LONG_HOLD_AFTER &&
                   field_chars_due.size() > 0) begin
        long_hold_done = 1;
        hold_left = LONG_HOLD_CYCLES - 1;
        field_ch.ready <= 1'b0;
      end else if (pending_bytes.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 10) - 1;
        field_ch.ready <= 1'b0;
      end else begin
        field_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up after a long stretch with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (field_ch.valid && field_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sentence_no;
    int random_start;
    bit mid_drain;

    for (int i = 0; i < HDR_LEN; i++) hdr_win[i] = 8'h00;
    hdr_fill    = 0;
    in_sentence = 0;
    sent_len    = 0;
    bytes_taken = 0;
    fail_count  = 0;
    idle_cycles = 0;
    long_hold_done = 0;
    sentence_no = 0;
    mid_drain   = 0;

    // Directed: a star with nothing captured, then one compact sentence with
    // all-zero and all-one bytes, hemisphere letters and an unterminated date.
    push_text("*");
    push_text("$GPRMC,");
    pending_bytes.push_back(8'h00);
    push_text(",A,");
    pending_bytes.push_back(8'hFF);
    push_text("9,N,0,E,,,1");
    pending_bytes.push_back(8'h7F);
    push_text("*");
    pending_bytes.push_back(DRAIN_MARK);

    // Random: walk every shape once, then pick shapes at random.
    random_start = pending_bytes.size();
    while (pending_bytes.size() - random_start < RANDOM_BYTES) begin
      queue_random_sentence((sentence_no < 5) ? sentence_no : $urandom_range(0, 9));
      sentence_no++;
      if (!mid_drain && pending_bytes.size() - random_start >= RANDOM_BYTES / 2) begin
        pending_bytes.push_back(DRAIN_MARK);
        mid_drain = 1;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() > 0 || byte_ch.valid || field_chars_due.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && field_chars_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### nmea_rmc_field_extractor_core.f
+incdir+rtl/core
rtl/core/rmc_pkg.sv
rtl/core/rmc_byte_if.sv
rtl/core/rmc_result_if.sv
rtl/core/rmc_datapath.sv
rtl/core/rmc_ctrl.sv
rtl/core/nmea_rmc_field_extractor_core.sv
tb/nmea_rmc_field_extractor_core_tb.sv
